/* sv/sha2_256_384_hash_engine_top_assert.svh */
// Assertion macros used by the SHA-2 compression engine.
`ifndef SHA2_256_384_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA2_256_384_HASH_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SHA2_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define SHA2_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sha2_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-2 engine package
// Round constants, initial vectors, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package sha2_pkg;

   localparam logic [63:0] KCONST [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam logic [63:0] IV256 [8] = '{
      64'h6a09e667, 64'hbb67ae85, 64'h3c6ef372, 64'ha54ff53a,
      64'h510e527f, 64'h9b05688c, 64'h1f83d9ab, 64'h5be0cd19
   };

   localparam logic [63:0] IV384 [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam int unsigned QDEPTH = 2;

   // Classified input word waiting for the engine.
   typedef struct packed {
      logic [63:0] word;      // data, already masked and padded when short
      logic [6:0]  bits_add;  // message bits this word contributes
      logic        last;
      logic        mark;      // full last word: pad byte goes in a word of its own
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } eng_state_type;

endpackage

/* sv/sha2_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-2 front end
// Accepts message words, classifies and pre-pads them, and queues them.
// ----------------------------------------------------------------------------
module sha2_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [71:0]          req_tdata,   // data_word [63:0], byte_count [67:64]
   input  logic                 req_tlast,   // last_in
   input  logic                 pop,
   output logic                 head_valid,
   output sha2_pkg::q_entry_type head
);
   import sha2_pkg::*;

   q_entry_type q_ff [QDEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic [3:0]  bc;
   logic        full8;
   logic [6:0]  sh;
   q_entry_type entry;
   logic        push;

   always_comb begin
      bc    = (req_tdata[67:64] > 4'd8) ? 4'd8 : req_tdata[67:64];
      full8 = !req_tlast || (bc == 4'd8);
      sh    = 7'd64 - {bc, 3'b000};
      entry.word     = full8 ? req_tdata[63:0]
                     : ((req_tdata[63:0] & (~64'd0 << sh)) | (64'h80 << (sh - 7'd8)));
      entry.bits_add = full8 ? 7'd64 : {1'b0, bc[2:0], 3'b000};
      entry.last     = req_tlast;
      entry.mark     = req_tlast && (bc == 4'd8);
   end

   assign req_tready = (count_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* sv/sha2_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-2 compression engine
// Fills the block, pads the message, runs one round per cycle, emits digest.
// ----------------------------------------------------------------------------
`include "sha2_256_384_hash_engine_top_assert.svh"

module sha2_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  sha2_pkg::q_entry_type head,
   output logic                 pop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,   // digest_word [63:0]
   output logic                 rsp_tlast    // digest_last
);
   import sha2_pkg::*;

   eng_state_type state_ff, state_in;
   logic          mode_ff, mode_in;
   logic [63:0]   chain_ff [8];
   logic [63:0]   chain_in [8];
   logic [63:0]   vars_ff [8];
   logic [63:0]   vars_in [8];
   logic [63:0]   win_ff [16];
   logic [63:0]   win_in [16];
   logic [3:0]    wf_ff, wf_in;
   logic [63:0]   bits_ff, bits_in;
   logic [6:0]    round_ff, round_in;
   logic          mark_ff, mark_in;
   logic          chk_ff, chk_in;
   logic          pad_ff, pad_in;
   logic          done_ff, done_in;
   logic [2:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          csr_write;
   logic          blk_full;
   logic          app_en;
   logic [63:0]   app_word;
   logic [63:0]   msk;
   logic [6:0]    last_round;
   logic [2:0]    last_idx;
   logic          out_load;
   logic [63:0]   kr, w_new, t1, t2;
   logic [63:0]   va, vb, vc, vd, ve, vf, vg, vh;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n,
                                        input logic m);
      logic [63:0] lo;
      lo = {32'd0, x[31:0]};
      if (m) begin
         rotr = (x >> n) | (x << (64 - n));
      end else begin
         rotr = ((lo >> n) | (lo << (32 - n))) & 64'h0000_0000_ffff_ffff;
      end
   endfunction

   function automatic logic [63:0] bsig0(input logic [63:0] x, input logic m);
      bsig0 = m ? (rotr(x, 28, m) ^ rotr(x, 34, m) ^ rotr(x, 39, m))
                : (rotr(x, 2, m) ^ rotr(x, 13, m) ^ rotr(x, 22, m));
   endfunction

   function automatic logic [63:0] bsig1(input logic [63:0] x, input logic m);
      bsig1 = m ? (rotr(x, 14, m) ^ rotr(x, 18, m) ^ rotr(x, 41, m))
                : (rotr(x, 6, m) ^ rotr(x, 11, m) ^ rotr(x, 25, m));
   endfunction

   function automatic logic [63:0] ssig0(input logic [63:0] x, input logic m);
      ssig0 = m ? (rotr(x, 1, m) ^ rotr(x, 8, m) ^ (x >> 7))
                : (rotr(x, 7, m) ^ rotr(x, 18, m) ^ ({32'd0, x[31:0]} >> 3));
   endfunction

   function automatic logic [63:0] ssig1(input logic [63:0] x, input logic m);
      ssig1 = m ? (rotr(x, 19, m) ^ rotr(x, 61, m) ^ (x >> 6))
                : (rotr(x, 17, m) ^ rotr(x, 19, m) ^ ({32'd0, x[31:0]} >> 10));
   endfunction

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign pop        = (state_ff == ST_IDLE) && head_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign msk        = mode_ff ? ~64'd0 : 64'h0000_0000_ffff_ffff;
   assign last_round = mode_ff ? 7'd79 : 7'd63;
   assign last_idx   = mode_ff ? 3'd5 : 3'd3;
   assign blk_full   = mode_ff ? (wf_ff == 4'd15) : (wf_ff == 4'd7);
   assign out_load   = !rsp_valid_ff || rsp_tready;

   // round datapath
   always_comb begin
      va = vars_ff[0]; vb = vars_ff[1]; vc = vars_ff[2]; vd = vars_ff[3];
      ve = vars_ff[4]; vf = vars_ff[5]; vg = vars_ff[6]; vh = vars_ff[7];
      kr = mode_ff ? KCONST[round_ff] : {32'd0, KCONST[round_ff][63:32]};
      w_new = (ssig1(win_ff[14], mode_ff) + win_ff[9] + ssig0(win_ff[1], mode_ff)
               + win_ff[0]) & msk;
      t1 = (vh + bsig1(ve, mode_ff) + ((ve & vf) ^ (~ve & vg)) + kr + win_ff[0]) & msk;
      t2 = (bsig0(va, mode_ff) + ((va & vb) ^ (va & vc) ^ (vb & vc))) & msk;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (blk_full) state_in = ST_ROUND;
               else if (head.last) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (blk_full) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == last_round) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (done_ff) state_in = ST_OUT;
            else if (pad_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (out_load && (idx_ff == last_idx)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write) state_in = ST_IDLE;
   end

   // datapath and outputs
   always_comb begin
      mode_in      = mode_ff;
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      win_in       = win_ff;
      wf_in        = wf_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      mark_in      = mark_ff;
      chk_in       = chk_ff;
      pad_in       = pad_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      app_en       = 1'b0;
      app_word     = 64'd0;

      if (rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               app_en   = 1'b1;
               app_word = head.word;
               bits_in  = bits_ff + {57'd0, head.bits_add};
               if (head.last) begin
                  pad_in  = 1'b1;
                  mark_in = head.mark;
                  chk_in  = 1'b1;
               end
            end
         end
         ST_PAD: begin
            app_en = 1'b1;
            if (mark_ff) begin
               app_word = 64'h80 << 56;
               mark_in  = 1'b0;
            end else if (chk_ff && mode_ff && (wf_ff == 4'd15)) begin
               // pad byte took the upper length slot: spill to one more block
               chk_in = 1'b0;
            end else if (!blk_full) begin
               chk_in = 1'b0;
            end else begin
               app_word = bits_ff;
               done_in  = 1'b1;
               pad_in   = 1'b0;
            end
         end
         ST_ROUND: begin
            for (int j = 1; j < 8; j++) vars_in[j] = vars_ff[j - 1];
            vars_in[4] = (vd + t1) & msk;
            vars_in[0] = (t1 + t2) & msk;
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
            win_in[15] = w_new;
            round_in   = round_ff + 7'd1;
         end
         ST_FINAL: begin
            for (int i = 0; i < 8; i++) chain_in[i] = (chain_ff[i] + vars_ff[i]) & msk;
            round_in = 7'd0;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mode_ff ? chain_ff[0] : {chain_ff[0][31:0], chain_ff[1][31:0]};
               rsp_last_in  = (idx_ff == last_idx);
               idx_in       = idx_ff + 3'd1;
               // advance the chain toward the next digest word
               if (mode_ff) begin
                  for (int i = 0; i < 7; i++) chain_in[i] = chain_ff[i + 1];
               end else begin
                  for (int i = 0; i < 6; i++) chain_in[i] = chain_ff[i + 2];
               end
               if (idx_ff == last_idx) begin
                  if (mode_ff) begin
                     chain_in = IV384;
                  end else begin
                     chain_in = IV256;
                  end
                  wf_in    = 4'd0;
                  bits_in  = 64'd0;
                  done_in  = 1'b0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
                  chk_in   = 1'b0;
                  idx_in   = 3'd0;
               end
            end
         end
         default: ;
      endcase

      if (app_en) begin
         if (mode_ff) begin
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
            win_in[15] = app_word;
         end else begin
            for (int i = 0; i < 14; i++) win_in[i] = win_ff[i + 2];
            win_in[14] = {32'd0, app_word[63:32]};
            win_in[15] = {32'd0, app_word[31:0]};
         end
         if (blk_full) begin
            wf_in    = 4'd0;
            vars_in  = chain_ff;
            round_in = 7'd0;
         end else begin
            wf_in = wf_ff + 4'd1;
         end
      end

      if (csr_write) begin
         mode_in  = csr_wdata;
         if (csr_wdata) begin
            chain_in = IV384;
         end else begin
            chain_in = IV256;
         end
         wf_in    = 4'd0;
         bits_in  = 64'd0;
         round_in = 7'd0;
         mark_in  = 1'b0;
         chk_in   = 1'b0;
         pad_in   = 1'b0;
         done_in  = 1'b0;
         idx_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         chain_ff     <= IV256;
         wf_ff        <= 4'd0;
         bits_ff      <= 64'd0;
         round_ff     <= 7'd0;
         mark_ff      <= 1'b0;
         chk_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         done_ff      <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         chain_ff     <= chain_in;
         wf_ff        <= wf_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         mark_ff      <= mark_in;
         chk_ff       <= chk_in;
         pad_ff       <= pad_in;
         done_ff      <= done_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff     <= vars_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `SHA2_ASSERT_NOW(a_round_range, clock, reset, state_ff == ST_ROUND, (mode_ff ? (round_ff < 7'd80) : (round_ff < 7'd64)), "round index beyond round count")
   `SHA2_ASSERT_NOW(a_fill_256, clock, reset, !mode_ff, wf_ff < 4'd8, "SHA-256 block overfilled")
   `SHA2_ASSERT_NEXT(a_final_to_out, clock, reset, (state_ff == ST_FINAL) && done_ff && !csr_valid, state_ff == ST_OUT, "length block done without digest")

endmodule

/* sv/sha2_256_384_hash_engine_top.sv */
`timescale 1ns / 1ps
// A block holds 8 message words (SHA-256) or 16 (SHA-384) and is then compressed in
// the one-round-per-cycle core; the engine takes no new word while a block is compressed.
// The last word is followed by pad words, one or two blocks, then 4 or 6 digest words.
// Reset (synchronous, active high) selects SHA-256, loads its initial vector, empties the queue.
// ----------------------------------------------------------------------------
// SHA-256 / SHA-384 hash engine
// Front end queue feeding a sequenced compression engine.
// ----------------------------------------------------------------------------
module sha2_256_384_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_word [63:0], byte_count [67:64], zero [71:68]
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // digest_word [63:0]
   output logic        rsp_tlast,   // digest_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata    // mode
);
   import sha2_pkg::*;

   q_entry_type head;
   logic        head_valid;
   logic        pop;

   sha2_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   sha2_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 / SHA-384 hash engine testbench
// Streams messages of random length and content in both modes, predicts each
// digest with a local SHA-2 model, and compares every digest word and its
// last flag in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import sha2_pkg::*;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } msg_word_type;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
   } digest_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_wdata;

   sha2_256_384_hash_engine_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // hash state of the model
   logic        sha384;
   logic [63:0] chain [8];
   logic [63:0] block_buf [16];
   int          words_in;
   logic [63:0] bit_count;

   msg_word_type pending_words [$];
   digest_type   digest_queue [$];
   int           n_errors;
   int           cycle_count;
   int           burst_left;
   int           gap_left;
   int           stall_phase;
   logic [3:0]   stall_mask;
   logic         csr_req;
   logic         csr_val;

   initial clock = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rot(logic [63:0] x, int n);
      if (sha384)
         return (x >> n) | (x << (64 - n));
      return ((x >> n) | (x << (32 - n))) & 64'hffffffff;
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++)
         chain[i] = sha384 ? IV384[i] : IV256[i];
      for (int i = 0; i < 16; i++)
         block_buf[i] = '0;
      words_in  = 0;
      bit_count = '0;
   endtask

   task automatic compress_block();
      logic [63:0] v [8];
      logic [63:0] msk;
      logic [63:0] w, k, t1, t2, s0, s1, e0, e1;
      int          rounds;
      msk    = sha384 ? '1 : 64'hffffffff;
      rounds = sha384 ? 80 : 64;
      for (int i = 0; i < 8; i++)
         v[i] = chain[i];
      for (int t = 0; t < rounds; t++) begin
         if (t < 16) begin
            w = block_buf[t];
         end else begin
            e0 = block_buf[(t - 15) & 15];
            e1 = block_buf[(t - 2) & 15];
            s0 = sha384 ? rot(e0, 1) ^ rot(e0, 8) ^ (e0 >> 7)
                        : rot(e0, 7) ^ rot(e0, 18) ^ (e0 >> 3);
            s1 = sha384 ? rot(e1, 19) ^ rot(e1, 61) ^ (e1 >> 6)
                        : rot(e1, 17) ^ rot(e1, 19) ^ (e1 >> 10);
            w = (s1 + block_buf[(t - 7) & 15] + s0 + block_buf[t & 15]) & msk;
            block_buf[t & 15] = w;
         end
         k  = sha384 ? KCONST[t] : (KCONST[t] >> 32);
         s1 = sha384 ? rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41)
                     : rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25);
         s0 = sha384 ? rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39)
                     : rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22);
         t1 = (v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w) & msk;
         t2 = (s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]))) & msk;
         for (int j = 7; j > 0; j--)
            v[j] = v[j - 1];
         v[4] = (v[4] + t1) & msk;
         v[0] = (t1 + t2) & msk;
      end
      for (int i = 0; i < 8; i++)
         chain[i] = (chain[i] + v[i]) & msk;
      for (int i = 0; i < 16; i++)
         block_buf[i] = '0;
   endtask

   task automatic absorb_word(logic [63:0] w);
      if (sha384) begin
         block_buf[words_in] = w;
      end else begin
         block_buf[2 * words_in]     = w >> 32;
         block_buf[2 * words_in + 1] = w & 64'hffffffff;
      end
      words_in++;
      if (words_in >= (sha384 ? 16 : 8)) begin
         compress_block();
         words_in = 0;
      end
   endtask

   task automatic predict_digest(msg_word_type m);
      int          nb;
      int          bw;
      logic [63:0] keep;
      digest_type  d;
      nb = (m.nbytes > 8) ? 8 : m.nbytes;
      bw = sha384 ? 16 : 8;
      if (!m.last) begin
         absorb_word(m.word);
         bit_count += 64;
         return;
      end
      bit_count += 8 * nb;
      if (nb == 8) begin
         absorb_word(m.word);
         absorb_word(64'h80 << 56);
      end else begin
         keep = (nb == 0) ? '0 : ~64'h0 << (64 - 8 * nb);
         absorb_word((m.word & keep) | (64'h80 << (56 - 8 * nb)));
      end
      // the 128-bit length of SHA-384 needs one more zero word here
      if (sha384 && words_in == bw - 1)
         absorb_word('0);
      while (words_in != bw - 1)
         absorb_word('0);
      absorb_word(bit_count);
      for (int i = 0; i < (sha384 ? 6 : 4); i++) begin
         d.word = sha384 ? chain[i] : {chain[2 * i][31:0], chain[2 * i + 1][31:0]};
         d.last = (i == (sha384 ? 5 : 3));
         digest_queue.push_back(d);
      end
      restart_hash();
   endtask

   // driver: bursts and gaps, model updated on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_digest(pending_words.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {4'h0, pending_words[0].nbytes, pending_words[0].word};
               req_tlast  <= pending_words[0].last;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(20, 1);
                  gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall pattern plus digest checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
         stall_mask  <= 4'b1111;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_queue.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("unexpected digest word %h last %b", rsp_tdata, rsp_tlast);
            end else if (digest_queue[0].word !== rsp_tdata
                         || digest_queue[0].last !== rsp_tlast) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("digest mismatch: expected %h/%b, got %h/%b",
                           digest_queue[0].word, digest_queue[0].last, rsp_tdata, rsp_tlast);
               void'(digest_queue.pop_front());
            end else begin
               void'(digest_queue.pop_front());
            end
         end
         stall_phase <= stall_phase + 1;
         if (stall_phase % 64 == 63)
            stall_mask <= ($urandom_range(2, 0) == 0) ? 4'b1111 : 4'($urandom);
         rsp_tready <= stall_mask[stall_phase % 4];
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // csr write, driven and retired at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         csr_valid <= 1'b0;
         csr_req   <= 1'b0;
      end else if (csr_req && !csr_valid) begin
         csr_valid <= 1'b1;
         csr_wdata <= csr_val;
      end
   end

   task automatic add_word(logic [63:0] w, int nb, logic lst);
      msg_word_type m;
      m.word   = w;
      m.nbytes = 4'(nb);
      m.last   = lst;
      pending_words.push_back(m);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_message(int len, int last_nb);
      for (int i = 0; i < len; i++)
         add_word(rand64(), 8, 1'b0);
      add_word(rand64(), last_nb, 1'b1);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || digest_queue.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_val = m;
      csr_req = 1'b1;
      while (csr_req)
         @(posedge clock);
      // model restarts along with the block
      sha384 = m;
      restart_hash();
   endtask

   task automatic run_phase(int n_items);
      int count;
      int len;
      count = 0;
      while (count < n_items) begin
         len = (sha384 && $urandom_range(3, 0) == 0) ? $urandom_range(40, 0)
                                                      : $urandom_range(20, 0);
         if ($urandom_range(9, 0) == 0) begin
            // short non-last words: all eight bytes are taken
            for (int i = 0; i < len; i++)
               add_word(rand64(), $urandom_range(15, 0), 1'b0);
            add_word(rand64(), $urandom_range(15, 0), 1'b1);
         end else begin
            add_message(len, $urandom_range(8, 0));
         end
         count += len + 1;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_wdata   = 1'b0;
      csr_req     = 1'b0;
      csr_val     = 1'b0;
      n_errors    = 0;
      cycle_count = 0;
      sha384      = 1'b0;
      restart_hash();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, extreme words, byte counts up to 15, long runs
      add_word('0, 0, 1'b1);
      add_word('1, 8, 1'b1);
      add_word('0, 8, 1'b0);
      add_word('1, 15, 1'b1);
      add_word(64'h0123456789abcdef, 3, 1'b0);
      add_word('1, 9, 1'b1);
      add_message(6, 7);
      add_message(7, 8);
      add_message(7, 0);
      drain();
      write_mode(1'b1);
      add_word('0, 0, 1'b1);
      add_word('1, 8, 1'b1);
      add_message(13, 8);
      add_message(14, 8);
      add_message(14, 7);
      add_message(15, 0);
      drain();

      for (int p = 0; p < 4; p++) begin
         write_mode(p[0]);
         run_phase(90);
         drain();
      end

      if (n_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+sv
sv/sha2_pkg.sv
sv/sha2_front.sv
sv/sha2_engine.sv
sv/sha2_256_384_hash_engine_top.sv
verif/testbench.sv
